/* rtl/ale_pkg.sv */
// Package for the array list engine: field widths, codes, request and
// result structs, sequencer state and the compare-unit result type.
// No dependencies; imported by every module of the block except ale_ram.
package ale_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam int unsigned ActW  = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 8;
  localparam int unsigned StatW = 2;
  localparam int unsigned FidxW = 4;
  localparam int unsigned LenW  = 5;
  // position and count both fit here for any capacity up to 256
  localparam int unsigned CmpW  = PosW + 1;

  typedef enum logic [ActW-1:0] {
    ActInsert   = 3'd0,
    ActDelete   = 3'd1,
    ActLocate   = 3'd2,
    ActRetrieve = 3'd3,
    ActSorted   = 3'd4,
    ActClear    = 3'd5
  } ale_action_e;

  typedef enum logic [StatW-1:0] {
    StOk       = 2'd0,
    StBadPos   = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } ale_status_e;

  typedef enum logic {
    SeqIdle,
    SeqRun
  } ale_state_e;

  typedef struct packed {
    logic [ActW-1:0]         action;
    logic signed [DataW-1:0] data;
    logic [PosW-1:0]         position;
  } ale_req_t;

  typedef struct packed {
    logic [StatW-1:0]        status;
    logic signed [DataW-1:0] read_value;
    logic [FidxW-1:0]        found_index;
    logic [LenW-1:0]         length;
  } ale_rsp_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } ale_cmp_t;

endpackage

/* rtl/array_list_engine_unit.sv */
// Array list engine top level: sequencer, entry RAM and compare unit.
// Depends on ale_pkg, ale_ram, ale_cmp and ale_ctrl.
//
//   channel   | ports                     | handshake
//   ----------+---------------------------+----------------------------------
//   request   | start_i, req_i, busy_o    | taken when start_i && !busy_o
//   result    | done_o, rsp_o             | one-cycle strobe, no backpressure
//
// Errors, clear and unknown actions answer in the cycle after the request.
// Insert moves the entries from the position up, delete those above it; sorted
// insert moves the entries above the value; locate scans from index 0 to the
// first match or the end of the list; retrieve reads one entry. The single RAM
// read port moves or scans one entry per cycle.
// Reset empties the list; busy_o stays high while a request runs, no stalls.
module array_list_engine_unit #(
  parameter int unsigned Capacity = ale_pkg::DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ale_pkg::ale_req_t req_i,
  output logic              busy_o,
  output logic              done_o,
  output ale_pkg::ale_rsp_t rsp_o
);
  import ale_pkg::*;

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;

  logic                    rd_en;
  logic [AddrW-1:0]        rd_addr;
  logic signed [DataW-1:0] rd_data;
  logic                    wr_en;
  logic [AddrW-1:0]        wr_addr;
  logic signed [DataW-1:0] wr_data;
  logic signed [DataW-1:0] key;
  ale_cmp_t                cmp;

  ale_ram #(
    .Width(DataW),
    .Depth(Capacity)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  ale_cmp u_cmp (
    .word_i(rd_data),
    .key_i (key),
    .cmp_o (cmp)
  );

  ale_ctrl #(
    .Capacity(Capacity)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .rsp_o    (rsp_o),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .key_o    (key),
    .cmp_i    (cmp)
  );

endmodule

/* rtl/ale_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/ale_cmp.sv */
// Shared compare unit: signed greater-than and equality of a stored
// word against the request value. Depends on ale_pkg.
module ale_cmp (
  input  logic signed [ale_pkg::DataW-1:0] word_i,
  input  logic signed [ale_pkg::DataW-1:0] key_i,
  output ale_pkg::ale_cmp_t                cmp_o
);
  import ale_pkg::*;

  always_comb begin
    cmp_o.eq = (word_i == key_i);
    cmp_o.gt = (word_i > key_i);
  end

endmodule

/* rtl/ale_ctrl.sv */
// Sequencer for the array list engine: request checks, element count,
// one-entry-per-cycle shift/scan loop over the RAM, result register.
// Depends on ale_pkg; drives ale_ram and reads ale_cmp.
module ale_ctrl #(
  parameter int unsigned Capacity = ale_pkg::DefCapacity,
  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  ale_pkg::ale_req_t                req_i,
  output logic                             busy_o,
  output logic                             done_o,
  output ale_pkg::ale_rsp_t                rsp_o,
  output logic                             rd_en_o,
  output logic [AddrW-1:0]                 rd_addr_o,
  input  logic signed [ale_pkg::DataW-1:0] rd_data_i,
  output logic                             wr_en_o,
  output logic [AddrW-1:0]                 wr_addr_o,
  output logic signed [ale_pkg::DataW-1:0] wr_data_o,
  output logic signed [ale_pkg::DataW-1:0] key_o,
  input  ale_pkg::ale_cmp_t                cmp_i
);
  import ale_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  ale_state_e              state_q, state_d;
  logic [ActW-1:0]         act_q, act_d;
  logic signed [DataW-1:0] data_q, data_d;
  logic [AddrW-1:0]        gap_q, gap_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         rd_idx_q, rd_idx_d;
  logic [CntW-1:0]         wr_idx_q, wr_idx_d;
  logic [CntW-1:0]         left_q, left_d;
  logic                    pend_q, pend_d;
  logic                    done_q, done_d;
  ale_rsp_t                rsp_q, rsp_d;

  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic            issue;
  logic            moving_down;
  logic            last;

  assign pos_ext = CmpW'(req_i.position);
  assign cnt_ext = CmpW'(cnt_q);

  assign issue       = (left_q != '0);
  assign moving_down = (act_q == ActInsert) || (act_q == ActSorted);
  assign last        = !issue && !pend_q;

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    data_d   = data_q;
    gap_d    = gap_q;
    cnt_d    = cnt_q;
    rd_idx_d = rd_idx_q;
    wr_idx_d = wr_idx_q;
    left_d   = left_q;
    pend_d   = 1'b0;
    done_d   = 1'b0;
    rsp_d    = rsp_q;

    rd_en_o   = 1'b0;
    rd_addr_o = rd_idx_q[AddrW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = wr_idx_q[AddrW-1:0];
    wr_data_o = rd_data_i;

    case (state_q)
      SeqIdle: begin
        if (start_i) begin
          act_d  = req_i.action;
          data_d = req_i.data;
          gap_d  = AddrW'(req_i.position);
          rsp_d.status      = StOk;
          rsp_d.read_value  = '0;
          rsp_d.found_index = '0;
          rsp_d.length      = LenW'(cnt_q);
          case (req_i.action)
            ActInsert: begin
              if (pos_ext > cnt_ext) begin
                rsp_d.status = StBadPos;
                done_d       = 1'b1;
              end else if (cnt_ext == CmpW'(Capacity)) begin
                rsp_d.status = StFull;
                done_d       = 1'b1;
              end else begin
                rd_idx_d = cnt_q - CntW'(1);
                left_d   = CntW'(cnt_ext - pos_ext);
                state_d  = SeqRun;
              end
            end
            ActDelete: begin
              if (pos_ext >= cnt_ext) begin
                rsp_d.status = StBadPos;
                done_d       = 1'b1;
              end else begin
                rd_idx_d = CntW'(pos_ext + CmpW'(1));
                left_d   = CntW'(cnt_ext - pos_ext - CmpW'(1));
                state_d  = SeqRun;
              end
            end
            ActLocate: begin
              rd_idx_d = '0;
              left_d   = cnt_q;
              state_d  = SeqRun;
            end
            ActRetrieve: begin
              if (pos_ext >= cnt_ext) begin
                rsp_d.status = StBadPos;
                done_d       = 1'b1;
              end else begin
                rd_idx_d = CntW'(pos_ext);
                left_d   = CntW'(1);
                state_d  = SeqRun;
              end
            end
            ActSorted: begin
              if (cnt_ext == CmpW'(Capacity)) begin
                rsp_d.status = StFull;
                done_d       = 1'b1;
              end else begin
                gap_d    = '0;
                rd_idx_d = cnt_q - CntW'(1);
                left_d   = cnt_q;
                state_d  = SeqRun;
              end
            end
            ActClear: begin
              cnt_d        = '0;
              rsp_d.length = '0;
              done_d       = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      SeqRun: begin
        // read one entry per cycle; its data lands next cycle at wr_idx_q
        if (issue) begin
          rd_en_o = 1'b1;
          pend_d  = 1'b1;
          left_d  = left_q - CntW'(1);
          if (moving_down) begin
            rd_idx_d = rd_idx_q - CntW'(1);
            wr_idx_d = rd_idx_q + CntW'(1);
          end else begin
            rd_idx_d = rd_idx_q + CntW'(1);
            wr_idx_d = (act_q == ActDelete) ? rd_idx_q - CntW'(1) : rd_idx_q;
          end
        end

        case (act_q)
          ActInsert: begin
            if (pend_q) begin
              wr_en_o = 1'b1;
            end else if (last) begin
              wr_en_o   = 1'b1;
              wr_addr_o = gap_q;
              wr_data_o = data_q;
              cnt_d     = cnt_q + CntW'(1);
              done_d    = 1'b1;
            end
          end
          ActDelete: begin
            if (pend_q) begin
              wr_en_o = 1'b1;
            end else if (last) begin
              cnt_d  = cnt_q - CntW'(1);
              done_d = 1'b1;
            end
          end
          ActSorted: begin
            if (pend_q) begin
              wr_en_o = 1'b1;
              // first entry not above the value: value goes just above it
              if (!cmp_i.gt) begin
                wr_data_o = data_q;
                cnt_d     = cnt_q + CntW'(1);
                done_d    = 1'b1;
              end
            end else if (last) begin
              wr_en_o   = 1'b1;
              wr_addr_o = gap_q;
              wr_data_o = data_q;
              cnt_d     = cnt_q + CntW'(1);
              done_d    = 1'b1;
            end
          end
          ActLocate: begin
            if (pend_q && cmp_i.eq) begin
              rsp_d.found_index = FidxW'(wr_idx_q);
              done_d            = 1'b1;
            end else if (last) begin
              rsp_d.status = StNotFound;
              done_d       = 1'b1;
            end
          end
          ActRetrieve: begin
            if (pend_q) begin
              rsp_d.read_value = rd_data_i;
              done_d           = 1'b1;
            end
          end
          default: begin
            done_d = 1'b1;
          end
        endcase

        if (done_d) begin
          rsp_d.length = LenW'(cnt_d);
          pend_d       = 1'b0;
          state_d      = SeqIdle;
        end
      end

      default: begin
        state_d = SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeqIdle;
      cnt_q   <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    data_q   <= data_d;
    gap_q    <= gap_d;
    rd_idx_q <= rd_idx_d;
    wr_idx_q <= wr_idx_d;
    rsp_q    <= rsp_d;
  end

  assign busy_o = (state_q != SeqIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign key_o  = data_q;

endmodule

/* test/array_list_engine_unit_test.sv */
// Self-checking testbench for array_list_engine_unit: directed and random requests,
// each checked against a shadow copy of the list kept in a small scoreboard class.
// Depends on ale_pkg and the array_list_engine_unit RTL.
module array_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ale_pkg::*;

  localparam int unsigned Cap = DefCapacity;
  localparam int NumRandom = 1850;
  localparam int SettleCycles = 40;

  // Shadow of the list; predicts the answer for each accepted request.
  class list_shadow;
    logic signed [DataW-1:0] entry [Cap];
    int unsigned count;
    ale_rsp_t answers [$];
    int mismatches;

    function new();
      count = 0;
      mismatches = 0;
    endfunction

    function void note_request(ale_req_t req);
      ale_rsp_t want;
      int unsigned n;
      int unsigned pos;
      int a;
      want = '0;
      n = count;
      pos = req.position;
      case (req.action)
        ActInsert: begin
          if (pos > n) begin
            want.status = StBadPos;
          end else if (n >= Cap) begin
            want.status = StFull;
          end else begin
            for (a = n; a > pos; a--) entry[a] = entry[a-1];
            entry[pos] = req.data;
            count = n + 1;
          end
        end
        ActDelete: begin
          if (pos >= n) begin
            want.status = StBadPos;
          end else begin
            for (a = pos; a + 1 < n; a++) entry[a] = entry[a+1];
            count = n - 1;
          end
        end
        ActLocate: begin
          want.status = StNotFound;
          for (a = 0; a < n; a++) begin
            if (entry[a] == req.data) begin
              want.status = StOk;
              want.found_index = a[FidxW-1:0];
              break;
            end
          end
        end
        ActRetrieve: begin
          if (pos >= n) want.status = StBadPos;
          else want.read_value = entry[pos];
        end
        ActSorted: begin
          if (n >= Cap) begin
            want.status = StFull;
          end else begin
            a = n;
            while (a > 0 && entry[a-1] > req.data) begin
              entry[a] = entry[a-1];
              a--;
            end
            entry[a] = req.data;
            count = n + 1;
          end
        end
        ActClear: count = 0;
        default: ;
      endcase
      want.length = count[LenW-1:0];
      answers.push_back(want);
    endfunction

    function void check_response(ale_rsp_t got);
      ale_rsp_t want;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding: status %0d len %0d",
                   $realtime, got.status, got.length);
        return;
      end
      want = answers.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.found_index !== want.found_index || got.length !== want.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: status %0d/%0d value %0d/%0d index %0d/%0d len %0d/%0d",
                   $realtime, want.status, got.status, want.read_value, got.read_value,
                   want.found_index, got.found_index, want.length, got.length);
      end
    endfunction

    function int outstanding();
      return answers.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  ale_req_t req_i;
  logic     busy_o;
  logic     done_o;
  ale_rsp_t rsp_o;

  list_shadow shadow = new();

  array_list_engine_unit #(.Capacity(Cap)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) shadow.check_response(rsp_o);
  end

  function automatic ale_req_t make_req(logic [ActW-1:0] act, logic signed [DataW-1:0] val,
                                        logic [PosW-1:0] pos);
    ale_req_t r;
    r.action = act;
    r.data = val;
    r.position = pos;
    return r;
  endfunction

  // Hold start until the block takes the request, then drop it for a nonzero gap.
  task automatic issue(input ale_req_t req, input int gap);
    start_i <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    shadow.note_request(req);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mode 0 grows the list, 1 shrinks it, 2 mixes, 3 leans on lookups
  function automatic logic [ActW-1:0] pick_action(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (r < 45) return ActInsert;
        if (r < 75) return ActSorted;
        if (r < 85) return ActLocate;
        if (r < 93) return ActRetrieve;
        if (r < 98) return ActDelete;
      end
      1: begin
        if (r < 15) return ActInsert;
        if (r < 25) return ActSorted;
        if (r < 40) return ActLocate;
        if (r < 55) return ActRetrieve;
        if (r < 97) return ActDelete;
      end
      2: begin
        if (r < 25) return ActInsert;
        if (r < 45) return ActSorted;
        if (r < 60) return ActLocate;
        if (r < 75) return ActRetrieve;
        if (r < 97) return ActDelete;
      end
      default: begin
        if (r < 20) return ActInsert;
        if (r < 35) return ActSorted;
        if (r < 65) return ActLocate;
        if (r < 85) return ActRetrieve;
        if (r < 97) return ActDelete;
      end
    endcase
    if (r < 99) return ActClear;
    return ActW'($urandom_range(6, 7));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return $signed($urandom_range(0, 8)) - 4;
    if (r < 6 && shadow.count > 0) return shadow.entry[$urandom_range(0, shadow.count - 1)];
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int mode;
    bit quiet;
    logic [PosW-1:0] pos;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    mode = 0;
    quiet = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list errors, ends of the list, extremes, ties, unknown actions
    issue(make_req(ActClear, 0, 0), 0);
    issue(make_req(ActRetrieve, 0, 0), 1);
    issue(make_req(ActDelete, 0, 0), 0);
    issue(make_req(ActLocate, 0, 0), 2);
    issue(make_req(ActInsert, 5, 1), 0);
    issue(make_req(ActInsert, 32'sh7fff_ffff, 0), 0);
    issue(make_req(ActInsert, 32'sh8000_0000, 1), 3);
    issue(make_req(ActInsert, 0, 0), 0);
    issue(make_req(ActInsert, 1, 8'hff), 0);
    issue(make_req(ActSorted, 7, 0), 1);
    issue(make_req(ActSorted, -1, 0), 0);
    issue(make_req(ActSorted, 7, 0), 0);
    issue(make_req(ActLocate, 7, 0), 0);
    issue(make_req(ActLocate, 123, 0), 4);
    issue(make_req(ActRetrieve, 0, 3), 0);
    issue(make_req(ActRetrieve, 0, 8'hff), 0);
    issue(make_req(ActDelete, 0, 0), 0);
    issue(make_req(ActDelete, 0, 4), 2);
    issue(make_req(ActDelete, 0, 200), 0);
    issue(make_req(3'd6, 32'sh5a5a_a5a5, 8'haa), 0);
    issue(make_req(3'd7, -1, 8'h55), 1);
    issue(make_req(ActClear, -1, 8'hff), 0);

    for (int i = 0; i < NumRandom; i++) begin
      if (i % 50 == 0) begin
        mode = $urandom_range(0, 3);
        quiet = ($urandom_range(0, 5) == 0);
      end
      if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(0, 255));
      else pos = PosW'($urandom_range(0, shadow.count + 1));
      issue(make_req(pick_action(mode), pick_value(), pos), pick_gap(quiet));
    end
    start_i <= 1'b0;

    while (shadow.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
